FILE: hdl/e2q_pkg.sv
package e2q_pkg;

	localparam int MaxStages     = 24;
	localparam int DpFrac        = 30;
	localparam int AngW          = 17;
	localparam int QuatW         = 16;
	localparam int DpW           = 34;
	localparam int ZW            = 30;
	localparam int ProdW         = 2 * DpW;
	localparam int CordicStages  = 16;
	localparam int OutFracBits   = 15;

	localparam logic signed [DpW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [ZW-1:0]  Deg90      = 30'sd94371840;
	localparam logic signed [ZW-1:0]  Deg180     = 30'sd188743680;
	localparam logic signed [ZW-1:0]  Deg360     = 30'sd377487360;

	typedef logic signed [ZW-1:0] atan_tab_t [MaxStages];
	localparam atan_tab_t AtanTab = '{
		30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
		30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
		30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
		30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14, 30'sd7
	};

	// one lane of a cordic cell: cos, sin, residual angle and fold flag
	typedef struct packed {
		logic signed [DpW-1:0] x;
		logic signed [DpW-1:0] y;
		logic signed [ZW-1:0]  z;
		logic                  neg;
	} lane_t;

	function automatic logic signed [DpW-1:0] mulr(logic signed [DpW-1:0] a,
			logic signed [DpW-1:0] b);
		logic signed [ProdW-1:0] p;
		p = ProdW'(a) * ProdW'(b) + (ProdW'(1) <<< (DpFrac - 1));
		return DpW'(p >>> DpFrac);
	endfunction

endpackage

FILE: hdl/e2q_cell.sv
module e2q_cell import e2q_pkg::*; #(
	parameter int Idx = 0
) (
	input  logic  clk,
	input  logic  en,
	input  lane_t lane_in  [3],
	output lane_t lane_out [3]
);

	lane_t nxt [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].neg = lane_in[k].neg;
			if (!lane_in[k].z[ZW-1]) begin
				nxt[k].x = lane_in[k].x - (lane_in[k].y >>> Idx);
				nxt[k].y = lane_in[k].y + (lane_in[k].x >>> Idx);
				nxt[k].z = lane_in[k].z - AtanTab[Idx];
			end else begin
				nxt[k].x = lane_in[k].x + (lane_in[k].y >>> Idx);
				nxt[k].y = lane_in[k].y - (lane_in[k].x >>> Idx);
				nxt[k].z = lane_in[k].z + AtanTab[Idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out <= nxt;
		end
	end

endmodule

FILE: hdl/e2q_combine.sv
module e2q_combine import e2q_pkg::*; #(
	parameter int OutFrac = OutFracBits
) (
	input  logic                    clk,
	input  logic [2:0]              en,
	input  lane_t                   lane_in [3],
	output logic signed [QuatW-1:0] quat [4]
);

	logic signed [DpW-1:0] cr, sr, cp, sp, cy, sy;
	logic signed [DpW-1:0] cc_s1, sc_s1, cs_s1, ss_s1, cy_s1, sy_s1;
	logic signed [DpW-1:0] t_s2 [8];
	logic signed [DpW:0]   sum [4];
	logic signed [DpW:0]   rnd [4];

	assign cr = lane_in[0].neg ? -lane_in[0].x : lane_in[0].x;
	assign sr = lane_in[0].neg ? -lane_in[0].y : lane_in[0].y;
	assign cp = lane_in[1].neg ? -lane_in[1].x : lane_in[1].x;
	assign sp = lane_in[1].neg ? -lane_in[1].y : lane_in[1].y;
	assign cy = lane_in[2].neg ? -lane_in[2].x : lane_in[2].x;
	assign sy = lane_in[2].neg ? -lane_in[2].y : lane_in[2].y;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cc_s1 <= mulr(cr, cp);
			sc_s1 <= mulr(sr, cp);
			cs_s1 <= mulr(cr, sp);
			ss_s1 <= mulr(sr, sp);
			cy_s1 <= cy;
			sy_s1 <= sy;
		end
		if (en[1]) begin
			t_s2[0] <= mulr(cc_s1, cy_s1);
			t_s2[1] <= mulr(ss_s1, sy_s1);
			t_s2[2] <= mulr(sc_s1, cy_s1);
			t_s2[3] <= mulr(cs_s1, sy_s1);
			t_s2[4] <= mulr(cs_s1, cy_s1);
			t_s2[5] <= mulr(sc_s1, sy_s1);
			t_s2[6] <= mulr(cc_s1, sy_s1);
			t_s2[7] <= mulr(ss_s1, cy_s1);
		end
	end

	always_comb begin
		sum[0] = (DpW+1)'(t_s2[0]) + (DpW+1)'(t_s2[1]);
		sum[1] = (DpW+1)'(t_s2[2]) - (DpW+1)'(t_s2[3]);
		sum[2] = (DpW+1)'(t_s2[4]) + (DpW+1)'(t_s2[5]);
		sum[3] = (DpW+1)'(t_s2[6]) - (DpW+1)'(t_s2[7]);
		for (int k = 0; k < 4; k++) begin
			if (OutFrac >= DpFrac) begin
				rnd[k] = sum[k];
			end else begin
				rnd[k] = (sum[k] + ((DpW+1)'(1) <<< (DpFrac - 1 - OutFrac)))
					>>> (DpFrac - OutFrac);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 4; k++) begin
				if (rnd[k] > 32767) begin
					quat[k] <= 16'sh7fff;
				end else if (rnd[k] < -32768) begin
					quat[k] <= 16'sh8000;
				end else begin
					quat[k] <= QuatW'(rnd[k]);
				end
			end
		end
	end

endmodule

FILE: hdl/euler_to_quaternion_unit.sv
// channel | signals                                      | role
// in      | in_valid in_ready roll/pitch/yaw_angle [16:0] | three angles, deg * 128
// out     | out_valid out_ready quat_w/x/y/z [15:0]       | unit quaternion, q1.15
//
// one item per cycle unless the output stalls; the chain is a fold register,
// one cordic cell per stage, two product stages and a round/saturate register
// every stage advances when its successor is empty or moves, so a stall at
// the output fills bubbles first and then holds the whole chain
// reset clears the valid bits only; data registers keep no reset
module euler_to_quaternion_unit import e2q_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStages,
	parameter int OUT_FRAC_BITS = OutFracBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [AngW-1:0] roll_angle,
	input  logic signed [AngW-1:0] pitch_angle,
	input  logic signed [AngW-1:0] yaw_angle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [QuatW-1:0] quat_w,
	output logic signed [QuatW-1:0] quat_x,
	output logic signed [QuatW-1:0] quat_y,
	output logic signed [QuatW-1:0] quat_z
);

	// stages above the table depth do nothing
	localparam int NCell  = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
	localparam int NStage = NCell + 4;

	logic [NStage-1:0] vld_q;
	logic [NStage-1:0] adv;
	lane_t             fold_s1 [3];
	lane_t             chain [NCell+1][3];
	lane_t             fold_nxt [3];
	logic signed [AngW-1:0] ang [3];
	logic signed [QuatW-1:0] quat [4];

	// a stage loads when it is free or its content moves on
	always_comb begin
		adv[NStage-1] = !vld_q[NStage-1] || out_ready;
		for (int i = NStage - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NStage-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NStage; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign ang[0] = roll_angle;
	assign ang[1] = pitch_angle;
	assign ang[2] = yaw_angle;

	// half angle into 2^-20 degree, wrap into +-180, fold into +-90
	always_comb begin
		logic signed [ZW-1:0] z;
		for (int k = 0; k < 3; k++) begin
			z = ZW'(ang[k]) <<< 12;
			if (z > Deg180) begin
				z = z - Deg360;
			end else if (z < -Deg180) begin
				z = z + Deg360;
			end
			fold_nxt[k].neg = 1'b0;
			if (z > Deg90) begin
				z = z - Deg180;
				fold_nxt[k].neg = 1'b1;
			end else if (z < -Deg90) begin
				z = z + Deg180;
				fold_nxt[k].neg = 1'b1;
			end
			fold_nxt[k].z = z;
			fold_nxt[k].x = CordicGain;
			fold_nxt[k].y = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			fold_s1 <= fold_nxt;
		end
	end

	assign chain[0] = fold_s1;

	for (genvar g = 0; g < NCell; g++) begin : g_cell
		e2q_cell #(.Idx(g)) u_cell (
			.clk      (clk),
			.en       (adv[g+1]),
			.lane_in  (chain[g]),
			.lane_out (chain[g+1])
		);
	end

	e2q_combine #(.OutFrac(OUT_FRAC_BITS)) u_combine (
		.clk     (clk),
		.en      (adv[NStage-1:NStage-3]),
		.lane_in (chain[NCell]),
		.quat    (quat)
	);

	assign quat_w = quat[0];
	assign quat_x = quat[1];
	assign quat_y = quat[2];
	assign quat_z = quat[3];

endmodule

FILE: hdl/e2q_checker.sv
module e2q_checker import e2q_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [QuatW-1:0] quat_w
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w))
		else $error("result changed while stalled");

	// an open output means the input side is open too
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// no result straight after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result after reset");

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quat_w    (quat_w)
);

FILE: sim/euler_to_quaternion_unit_tb.sv
`timescale 1ns / 100ps

module euler_to_quaternion_unit_tb;
	import e2q_pkg::*;

	localparam int      NumRandom = 480;
	localparam int      Pipe      = 1 + CordicStages + 3;
	localparam longint  DegOne    = 64'sd1048576;
	localparam longint  Gain      = 64'sd652032874;

	// arctangent of 2^-i, in 2^-20 degree
	localparam longint AtanDeg [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	typedef struct {
		logic signed [AngW-1:0] roll;
		logic signed [AngW-1:0] pitch;
		logic signed [AngW-1:0] yaw;
	} angles_t;

	typedef struct {
		logic signed [QuatW-1:0] w;
		logic signed [QuatW-1:0] x;
		logic signed [QuatW-1:0] y;
		logic signed [QuatW-1:0] z;
	} quat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [AngW-1:0] roll_angle;
	logic signed [AngW-1:0] pitch_angle;
	logic signed [AngW-1:0] yaw_angle;
	logic out_valid;
	logic out_ready;
	logic signed [QuatW-1:0] quat_w;
	logic signed [QuatW-1:0] quat_x;
	logic signed [QuatW-1:0] quat_y;
	logic signed [QuatW-1:0] quat_z;

	angles_t pending_angles [$];
	quat_t   expected_quats [$];
	int      err_cnt;
	int      sent_cnt;
	int      recv_cnt;
	int      in_gap;
	int      out_gap;
	int      hold_cnt;
	bit      hold_done;
	bit      in_took;
	bit      stim_done;

	euler_to_quaternion_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.roll_angle (roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle  (yaw_angle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z)
	);

	// fixed point helpers, 30 fraction bits
	function automatic longint round_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< (DpFrac - 1))) >>> DpFrac;
	endfunction

	function automatic logic signed [QuatW-1:0] round_sat(longint v);
		longint r;
		r = (v + (64'sd1 <<< (DpFrac - 1 - OutFracBits))) >>> (DpFrac - OutFracBits);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return QuatW'(r);
	endfunction

	// cos and sin of half the angle, rotation mode cordic in degrees
	task automatic half_angle_trig(input logic signed [AngW-1:0] ang,
			output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit     flip;
		z = longint'(ang) * 4096;
		x = Gain;
		y = 0;
		flip = 0;
		// wrap once into +-180, then fold beyond +-90
		if (z > 180 * DegOne)
			z -= 360 * DegOne;
		else if (z < -180 * DegOne)
			z += 360 * DegOne;
		if (z > 90 * DegOne) begin
			z -= 180 * DegOne;
			flip = 1;
		end else if (z < -90 * DegOne) begin
			z += 180 * DegOne;
			flip = 1;
		end
		for (int i = 0; i < CordicStages; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= AtanDeg[i];
			end else begin
				x += dx;
				y -= dy;
				z += AtanDeg[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// zyx product terms of the unit quaternion
	task automatic predict_quat(input angles_t a, output quat_t q);
		longint cr, sr, cp, sp, cy, sy;
		half_angle_trig(a.roll, cr, sr);
		half_angle_trig(a.pitch, cp, sp);
		half_angle_trig(a.yaw, cy, sy);
		q.w = round_sat(round_mul(round_mul(cr, cp), cy) + round_mul(round_mul(sr, sp), sy));
		q.x = round_sat(round_mul(round_mul(sr, cp), cy) - round_mul(round_mul(cr, sp), sy));
		q.y = round_sat(round_mul(round_mul(cr, sp), cy) + round_mul(round_mul(sr, cp), sy));
		q.z = round_sat(round_mul(round_mul(cr, cp), sy) - round_mul(round_mul(sr, sp), cy));
	endtask

	// append one angle set to the pending queue
	task automatic add_pending(input angles_t a);
		pending_angles = {pending_angles, a};
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// an angle that stresses the wrap and fold points, or anything at all
	function automatic logic signed [AngW-1:0] pick_angle();
		logic signed [AngW-1:0] special [8];
		int r;
		special = '{0, 23040, -23040, 46080, -46080, 65535, -65536, 1};
		r = $urandom_range(0, 99);
		if (r < 55)
			return AngW'($signed($urandom_range(0, 92160)) - 46080);
		if (r < 80)
			return AngW'($urandom());
		return special[$urandom_range(0, 7)] + AngW'($signed($urandom_range(0, 4)) - 2);
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// reset, once
	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// stimulus: directed corners first, then random angles
	initial begin
		angles_t a;
		logic signed [AngW-1:0] corners [12];
		stim_done = 0;
		corners = '{0, 46080, -46080, 23040, -23040, 23041, -23041, 23039,
			65535, -65536, -1, 1};
		for (int i = 0; i < 12; i++) begin
			a.roll = corners[i];
			a.pitch = corners[(i + 3) % 12];
			a.yaw = corners[(i + 7) % 12];
			add_pending(a);
		end
		// each axis alone at a right-angle half turn and a full turn
		add_pending('{23040, 0, 0});
		add_pending('{0, 23040, 0});
		add_pending('{0, 0, 23040});
		add_pending('{-46080, 0, 0});
		add_pending('{0, -46080, 0});
		add_pending('{0, 0, -46080});
		add_pending('{65535, 65535, 65535});
		add_pending('{-65536, -65536, -65536});
		add_pending('{11520, 11520, 11520});
		for (int i = 0; i < NumRandom; i++) begin
			a.roll = pick_angle();
			a.pitch = pick_angle();
			a.yaw = pick_angle();
			add_pending(a);
		end
		stim_done = 1;
	end

	// input driver, changes on the falling edge
	initial begin
		in_valid = 0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		out_ready = 0;
		in_took = 0;
		in_gap = 0;
		out_gap = 0;
		hold_cnt = 0;
		hold_done = 0;
	end

	always @(negedge clk) begin
		angles_t a;
		if (arst_n && (!in_valid || in_took)) begin
			in_took = 0;
			if (in_gap > 0) begin
				in_valid <= 0;
				in_gap--;
			end else if (pending_angles.size() > 0) begin
				a = pending_angles.pop_front();
				roll_angle <= a.roll;
				pitch_angle <= a.pitch;
				yaw_angle <= a.yaw;
				in_valid <= 1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver ready, with one long hold-off once traffic is flowing
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && sent_cnt >= 100) begin
				out_ready <= 0;
				hold_cnt++;
				if (hold_cnt >= 200)
					hold_done = 1;
			end else if (out_gap > 0) begin
				out_ready <= 0;
				out_gap--;
			end else begin
				out_ready <= 1;
				out_gap = pick_gap();
			end
		end
	end

	// input transfer: predict the quaternion
	always @(posedge clk) begin
		angles_t a;
		quat_t   q;
		if (arst_n && in_valid && in_ready) begin
			a.roll = roll_angle;
			a.pitch = pitch_angle;
			a.yaw = yaw_angle;
			predict_quat(a, q);
			expected_quats = {expected_quats, q};
			sent_cnt++;
			in_took = 1;
		end
	end

	// output transfer: compare with the oldest prediction
	always @(posedge clk) begin
		quat_t q;
		if (arst_n && out_valid && out_ready) begin
			recv_cnt++;
			if (expected_quats.size() == 0) begin
				$error("unexpected result w=%0d x=%0d y=%0d z=%0d",
					quat_w, quat_x, quat_y, quat_z);
				err_cnt++;
			end else begin
				q = expected_quats.pop_front();
				if (quat_w !== q.w) begin
					$error("quat_w expected %0d actual %0d", q.w, quat_w);
					err_cnt++;
				end
				if (quat_x !== q.x) begin
					$error("quat_x expected %0d actual %0d", q.x, quat_x);
					err_cnt++;
				end
				if (quat_y !== q.y) begin
					$error("quat_y expected %0d actual %0d", q.y, quat_y);
					err_cnt++;
				end
				if (quat_z !== q.z) begin
					$error("quat_z expected %0d actual %0d", q.z, quat_z);
					err_cnt++;
				end
			end
		end
	end

	// end of run
	initial begin
		err_cnt = 0;
		sent_cnt = 0;
		recv_cnt = 0;
		wait (stim_done);
		@(posedge clk);
		while (pending_angles.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_quats.size() > 0)
			@(posedge clk);
		repeat (Pipe * 2) @(posedge clk);
		if (expected_quats.size() > 0) begin
			$error("%0d results never arrived", expected_quats.size());
			err_cnt++;
		end
		$display("angle sets sent %0d, quaternions checked %0d, incl. wrap/fold corners",
			sent_cnt, recv_cnt);
		$display("output held off for 200 cycles once while input kept offering");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#3ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
